// ----- hdl/zhdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package zhdp_pkg;

    // Geometry
    localparam int ZONES_DEF = 4;
    localparam int HOURS     = 24;
    localparam int KIND_W    = 2;
    localparam int ZONE_W    = 3;
    localparam int HOUR_W    = 5;
    localparam int OBS_W     = 8;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 3;
    localparam int SUM_W     = 14;

    // Weights and limits
    localparam int MOTION_CAP    = 5;
    localparam int MOTION_SCORE  = 20;
    localparam int HIST_WEIGHT   = 70;
    localparam int RECENT_WEIGHT = 30;
    localparam int OLD_WEIGHT    = 80;
    localparam int NEW_WEIGHT    = 20;
    localparam int PCT_MAX       = 100;

    // Divide by 100 as multiply by reciprocal: exact for sums below 43690
    localparam int RECIP_100 = 5243;
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 19;

    typedef enum logic [KIND_W-1:0] {
        KIND_MOTION  = 2'd0,
        KIND_PREDICT = 2'd1,
        KIND_LEARN   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } state_t;

    // Default profile by hour of day
    function automatic logic [PCT_W-1:0] hour_base(input logic [HOUR_W-1:0] h);
        logic [PCT_W-1:0] v;
        if (h < 5'd6)
            v = 7'd10;
        else if (h < 5'd10)
            v = 7'd75;
        else if (h < 5'd16)
            v = 7'd40;
        else if (h < 5'd21)
            v = 7'd85;
        else
            v = 7'd25;
        return v;
    endfunction

    // Profile value after reset: hour default plus zone offset, clamped 0..100
    function automatic logic [PCT_W-1:0] reset_pct(input logic [1:0] z,
                                                   input logic [HOUR_W-1:0] h);
        logic signed [8:0] v;
        logic signed [8:0] ofs;
        logic [PCT_W-1:0]  r;
        case (z)
            2'd0:    ofs = 9'sd0;
            2'd1:    ofs = 9'sd8;
            2'd2:    ofs = -9'sd5;
            default: ofs = 9'sd5;
        endcase
        v = $signed({2'b00, hour_base(h)}) + ofs;
        if (v < 9'sd0)
            r = '0;
        else if (v > 9'sd100)
            r = 7'd100;
        else
            r = v[PCT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/zhdp_profile_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module zhdp_profile_ram #(
    parameter int DEPTH = 96,
    parameter int AW    = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic [zhdp_pkg::PCT_W-1:0]       rd_data,
    output logic                             rd_written,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [zhdp_pkg::PCT_W-1:0]  wr_data
);

    logic [zhdp_pkg::PCT_W-1:0] mem [0:DEPTH-1];
    logic [zhdp_pkg::PCT_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]           written_reg;
    logic                       rd_written_reg;

    // Profile storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Per-entry written flags; for an unwritten entry the predictor uses its reset profile
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_written = rd_written_reg;

endmodule

`default_nettype wire

// ----- hdl/zone_hour_demand_predictor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Zone/hour demand predictor.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; kind, zone, hour and observed are sampled at that edge.
// Kind motion bumps the zone's motion counter, kind predict returns a demand
// percent, kind learn folds an observation into the stored hourly profile.
// Result channel: valid is high for exactly one cycle with demand; it comes
// only for predict transactions, registered as the divide state ends.
// Busy is high after acceptance while the block is in its read and divide
// states; a new transaction is taken only once it falls. The profile RAM
// read is issued at the accepting edge, the read state forms the weighted
// sum from the read data, the divide state divides by 100 and writes back.
// The receiver cannot stall; the result is simply presented for one cycle.
// Reset: motion counters clear, all profile entries read as their hourly
// default plus zone offset until first learned; no clearing pass is needed,
// the block accepts a transaction as soon as reset is released.
module zone_hour_demand_predictor #(
    parameter int ZONES = zhdp_pkg::ZONES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [zhdp_pkg::KIND_W-1:0]   kind,
    input  wire logic [zhdp_pkg::ZONE_W-1:0]   zone,
    input  wire logic [zhdp_pkg::HOUR_W-1:0]   hour,
    input  wire logic [zhdp_pkg::OBS_W-1:0]    observed,
    output logic                               valid,
    output logic [zhdp_pkg::PCT_W-1:0]         demand
);

    localparam int DEPTH = ZONES * zhdp_pkg::HOURS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int PROD_W = zhdp_pkg::SUM_W + zhdp_pkg::RECIP_W;

    zhdp_pkg::state_t state_reg, state_next;

    logic [zhdp_pkg::KIND_W-1:0] kind_reg;
    logic [zhdp_pkg::ZONE_W-1:0] zone_reg;
    logic [zhdp_pkg::HOUR_W-1:0] hour_reg;
    logic [zhdp_pkg::OBS_W-1:0]  obs_reg;
    logic                        ok_reg;
    logic [AW-1:0]               addr_reg;
    logic [zhdp_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [zhdp_pkg::CNT_W-1:0]  cnt_reg [0:ZONES-1];
    logic [zhdp_pkg::CNT_W-1:0]  cnt_next;
    logic                        cnt_we;
    logic                        valid_reg, valid_next;
    logic [zhdp_pkg::PCT_W-1:0]  demand_reg, demand_next;

    logic                        accept;
    logic                        in_ok;
    logic [7:0]                  addr_full;
    logic [AW-1:0]               in_addr;
    logic [ZW-1:0]               zidx;
    logic [zhdp_pkg::CNT_W-1:0]  cnt_cur;
    logic [zhdp_pkg::PCT_W-1:0]  ram_data;
    logic                        ram_written;
    logic [zhdp_pkg::PCT_W-1:0]  hist;
    logic [zhdp_pkg::PCT_W-1:0]  recent;
    logic [zhdp_pkg::PCT_W-1:0]  obs_clip;
    logic [PROD_W-1:0]           prod;
    logic [zhdp_pkg::PCT_W-1:0]  quot;
    logic                        wr_en;

    // Input decode: zone and hour range check, table address zone*24+hour
    assign accept    = start && (state_reg == zhdp_pkg::ST_IDLE);
    assign in_ok     = (4'(zone) < 4'(ZONES)) && (hour < 5'(zhdp_pkg::HOURS));
    assign addr_full = ({5'd0, zone} << 4) + ({5'd0, zone} << 3) + {3'd0, hour};
    assign in_addr   = addr_full[AW-1:0];

    zhdp_profile_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept && in_ok),
        .rd_addr    (in_addr),
        .rd_data    (ram_data),
        .rd_written (ram_written),
        .wr_en      (wr_en),
        .wr_addr    (addr_reg),
        .wr_data    (quot)
    );

    // Operand selection
    assign zidx     = zone_reg[ZW-1:0];
    assign cnt_cur  = cnt_reg[zidx];
    assign hist     = ram_written ? ram_data
                                  : zhdp_pkg::reset_pct(zone_reg[1:0], hour_reg);
    assign recent   = ((7'(cnt_cur) * 7'(zhdp_pkg::MOTION_SCORE)) > 7'(zhdp_pkg::PCT_MAX))
                      ? 7'(zhdp_pkg::PCT_MAX) : 7'(cnt_cur) * 7'(zhdp_pkg::MOTION_SCORE);
    assign obs_clip = (obs_reg > 8'(zhdp_pkg::PCT_MAX)) ? 7'(zhdp_pkg::PCT_MAX)
                                                        : obs_reg[zhdp_pkg::PCT_W-1:0];

    // Divide by 100: reciprocal multiply, exact over the sum range
    assign prod = PROD_W'(sum_reg) * PROD_W'(zhdp_pkg::RECIP_100);
    always_comb
    begin
        if (prod[PROD_W-1:zhdp_pkg::RECIP_SH] > (PROD_W - zhdp_pkg::RECIP_SH)'(zhdp_pkg::PCT_MAX))
            quot = 7'(zhdp_pkg::PCT_MAX);
        else
            quot = prod[zhdp_pkg::RECIP_SH +: zhdp_pkg::PCT_W];
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_cur;
        cnt_we      = 1'b0;
        valid_next  = 1'b0;
        demand_next = demand_reg;
        wr_en       = 1'b0;
        case (state_reg)
            zhdp_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = zhdp_pkg::ST_READ;
            end
            zhdp_pkg::ST_READ:
            begin
                if (kind_reg == zhdp_pkg::KIND_LEARN)
                    sum_next = (14'(hist) * 14'(zhdp_pkg::OLD_WEIGHT))
                             + (14'(obs_clip) * 14'(zhdp_pkg::NEW_WEIGHT));
                else
                    sum_next = (14'(hist) * 14'(zhdp_pkg::HIST_WEIGHT))
                             + (14'(recent) * 14'(zhdp_pkg::RECENT_WEIGHT));
                state_next = zhdp_pkg::ST_DIV;
            end
            zhdp_pkg::ST_DIV:
            begin
                state_next = zhdp_pkg::ST_IDLE;
                case (zhdp_pkg::kind_t'(kind_reg))
                    zhdp_pkg::KIND_MOTION:
                    begin
                        if ((4'(zone_reg) < 4'(ZONES))
                            && (cnt_cur < 3'(zhdp_pkg::MOTION_CAP)))
                        begin
                            cnt_next = cnt_cur + 3'd1;
                            cnt_we   = 1'b1;
                        end
                    end
                    zhdp_pkg::KIND_PREDICT:
                    begin
                        valid_next  = 1'b1;
                        demand_next = ok_reg ? quot : '0;
                        if (ok_reg)
                        begin
                            cnt_next = cnt_cur >> 1;
                            cnt_we   = 1'b1;
                        end
                    end
                    zhdp_pkg::KIND_LEARN:
                    begin
                        wr_en = ok_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = zhdp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zhdp_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            for (int i = 0; i < ZONES; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cnt_we)
                cnt_reg[zidx] <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            zone_reg <= zone;
            hour_reg <= hour;
            obs_reg  <= observed;
            ok_reg   <= in_ok;
            addr_reg <= in_addr;
        end
        sum_reg    <= sum_next;
        demand_reg <= demand_next;
    end

    assign busy   = (state_reg != zhdp_pkg::ST_IDLE);
    assign valid  = valid_reg;
    assign demand = demand_reg;

endmodule

`default_nettype wire

// ----- tb/zone_hour_demand_predictor_tb.sv -----
`timescale 1ns / 1ps

module zone_hour_demand_predictor_tb;

    localparam int TB_ZONES    = 4;
    localparam int ITEM_TARGET = 1600;
    localparam int MAX_SHOWN   = 10;

    // Kind code with no operation behind it
    localparam logic [zhdp_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

    // Predicts the demand percent for each predict transaction and checks the
    // results that come back, in order.
    class demand_scoreboard;
        logic [zhdp_pkg::PCT_W-1:0] profile [TB_ZONES][zhdp_pkg::HOURS];
        logic [zhdp_pkg::CNT_W-1:0] motion_cnt [TB_ZONES];
        logic [zhdp_pkg::PCT_W-1:0] demand_q [$];
        int mismatches;
        int checked;
        int n_motion;
        int n_predict;
        int n_learn;
        int n_ignored;

        function new();
            int base;
            int offs [4];
            int lvl;
            offs = '{0, 8, -5, 5};
            // Power-up profile: hourly default plus zone offset, clamped
            for (int z = 0; z < TB_ZONES; z++)
            begin
                for (int h = 0; h < zhdp_pkg::HOURS; h++)
                begin
                    if (h < 6)
                        base = 10;
                    else if (h < 10)
                        base = 75;
                    else if (h < 16)
                        base = 40;
                    else if (h < 21)
                        base = 85;
                    else
                        base = 25;
                    lvl = base + offs[z % 4];
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > 100)
                        lvl = 100;
                    profile[z][h] = lvl[zhdp_pkg::PCT_W-1:0];
                end
                motion_cnt[z] = '0;
            end
            mismatches = 0;
            checked    = 0;
            n_motion   = 0;
            n_predict  = 0;
            n_learn    = 0;
            n_ignored  = 0;
        endfunction

        // Accepted command: update the model state, queue any expected demand
        function void note_command(logic [zhdp_pkg::KIND_W-1:0] k,
                                   logic [zhdp_pkg::ZONE_W-1:0] z,
                                   logic [zhdp_pkg::HOUR_W-1:0] h,
                                   logic [zhdp_pkg::OBS_W-1:0] obs);
            bit zone_ok;
            bit hour_ok;
            int recent;
            int sum;
            int o;
            zone_ok = int'(z) < TB_ZONES;
            hour_ok = int'(h) < zhdp_pkg::HOURS;
            case (k)
                zhdp_pkg::KIND_MOTION:
                begin
                    if (zone_ok)
                    begin
                        n_motion++;
                        if (motion_cnt[z] < zhdp_pkg::MOTION_CAP)
                            motion_cnt[z] = motion_cnt[z] + 1'b1;
                    end
                    else
                        n_ignored++;
                end
                zhdp_pkg::KIND_PREDICT:
                begin
                    n_predict++;
                    sum = 0;
                    if (zone_ok && hour_ok)
                    begin
                        recent = int'(motion_cnt[z]) * zhdp_pkg::MOTION_SCORE;
                        if (recent > zhdp_pkg::PCT_MAX)
                            recent = zhdp_pkg::PCT_MAX;
                        sum = (int'(profile[z][h]) * zhdp_pkg::HIST_WEIGHT
                               + recent * zhdp_pkg::RECENT_WEIGHT) / 100;
                        if (sum > zhdp_pkg::PCT_MAX)
                            sum = zhdp_pkg::PCT_MAX;
                        motion_cnt[z] = motion_cnt[z] >> 1;
                    end
                    demand_q.push_back(sum[zhdp_pkg::PCT_W-1:0]);
                end
                zhdp_pkg::KIND_LEARN:
                begin
                    if (zone_ok && hour_ok)
                    begin
                        n_learn++;
                        o = (int'(obs) > zhdp_pkg::PCT_MAX) ? zhdp_pkg::PCT_MAX : int'(obs);
                        sum = (int'(profile[z][h]) * zhdp_pkg::OLD_WEIGHT
                               + o * zhdp_pkg::NEW_WEIGHT) / 100;
                        if (sum > zhdp_pkg::PCT_MAX)
                            sum = zhdp_pkg::PCT_MAX;
                        profile[z][h] = sum[zhdp_pkg::PCT_W-1:0];
                    end
                    else
                        n_ignored++;
                end
                default:
                    n_ignored++;
            endcase
        endfunction

        // Result strobe: compare against the oldest queued prediction
        function void check_demand(logic [zhdp_pkg::PCT_W-1:0] got);
            logic [zhdp_pkg::PCT_W-1:0] want;
            if (demand_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result, demand %0d", $realtime, got);
            end
            else
            begin
                want = demand_q.pop_front();
                checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: demand mismatch, expected %0d, got %0d",
                                 $realtime, want, got);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [zhdp_pkg::KIND_W-1:0]   kind;
    logic [zhdp_pkg::ZONE_W-1:0]   zone;
    logic [zhdp_pkg::HOUR_W-1:0]   hour;
    logic [zhdp_pkg::OBS_W-1:0]    observed;
    logic                          valid;
    logic [zhdp_pkg::PCT_W-1:0]    demand;

    demand_scoreboard   sb;
    bit                 idle_on;
    int                 useful;

    zone_hour_demand_predictor #(
        .ZONES(TB_ZONES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .zone(zone),
        .hour(hour),
        .observed(observed),
        .valid(valid),
        .demand(demand)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor: results first, then the command taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
                sb.check_demand(demand);
            if (start && !busy)
                sb.note_command(kind, zone, hour, observed);
        end
    end

    // Issue one command; called and returns at a falling edge
    task automatic issue(logic [zhdp_pkg::KIND_W-1:0] k, logic [zhdp_pkg::ZONE_W-1:0] z,
                         logic [zhdp_pkg::HOUR_W-1:0] h, logic [zhdp_pkg::OBS_W-1:0] obs);
        while (idle_on && $urandom_range(0, 99) < 17)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        zone     <= z;
        hour     <= h;
        observed <= obs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if ((k == zhdp_pkg::KIND_PREDICT)
            || (k != KIND_RESERVED && int'(z) < TB_ZONES
                && (k == zhdp_pkg::KIND_MOTION || int'(h) < zhdp_pkg::HOURS)))
            useful++;
    endtask

    function automatic logic [zhdp_pkg::ZONE_W-1:0] rand_zone();
        if ($urandom_range(0, 99) < 88)
            return zhdp_pkg::ZONE_W'($urandom_range(0, TB_ZONES - 1));
        return zhdp_pkg::ZONE_W'($urandom_range(TB_ZONES, 7));
    endfunction

    function automatic logic [zhdp_pkg::HOUR_W-1:0] rand_hour();
        if ($urandom_range(0, 99) < 90)
            return zhdp_pkg::HOUR_W'($urandom_range(0, zhdp_pkg::HOURS - 1));
        return zhdp_pkg::HOUR_W'($urandom_range(zhdp_pkg::HOURS, 31));
    endfunction

    function automatic logic [zhdp_pkg::OBS_W-1:0] rand_obs();
        if ($urandom_range(0, 99) < 70)
            return zhdp_pkg::OBS_W'($urandom_range(0, 100));
        return zhdp_pkg::OBS_W'($urandom_range(0, 255));
    endfunction

    // Stimulus
    initial
    begin
        int r;
        int burst;
        logic [zhdp_pkg::ZONE_W-1:0] z;
        sb       = new();
        idle_on  = 1'b1;
        useful   = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        kind     = zhdp_pkg::KIND_MOTION;
        zone     = '0;
        hour     = '0;
        observed = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: counter saturation, full score and halved motion counter
        repeat (6) issue(zhdp_pkg::KIND_MOTION, 3'd0, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd0, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd0, 5'd0, 8'd0);
        // Invalid zone or hour on predict: zero, counter kept
        issue(zhdp_pkg::KIND_MOTION, 3'd1, 5'd31, 8'd255);
        issue(zhdp_pkg::KIND_PREDICT, 3'd7, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd1, 5'd31, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd1, 5'd16, 8'd0);
        // Reset values with the negative and positive zone offsets
        issue(zhdp_pkg::KIND_PREDICT, 3'd2, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd3, 5'd23, 8'd0);
        // Learn: observation clamp, zero, full, and ignored forms
        issue(zhdp_pkg::KIND_LEARN, 3'd3, 5'd23, 8'd255);
        issue(zhdp_pkg::KIND_LEARN, 3'd2, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_LEARN, 3'd1, 5'd16, 8'd100);
        issue(zhdp_pkg::KIND_LEARN, 3'd4, 5'd5, 8'd200);
        issue(zhdp_pkg::KIND_LEARN, 3'd0, 5'd24, 8'd50);
        issue(zhdp_pkg::KIND_MOTION, 3'd5, 5'd0, 8'd0);
        issue(KIND_RESERVED, 3'd0, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd3, 5'd23, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd2, 5'd0, 8'd0);
        issue(zhdp_pkg::KIND_PREDICT, 3'd1, 5'd16, 8'd0);

        // Random: motion bursts followed by a predict, mixed with loose commands
        useful = 0;
        while (useful < ITEM_TARGET)
        begin
            idle_on = !(useful >= 600 && useful < 900);
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                z = zhdp_pkg::ZONE_W'($urandom_range(0, TB_ZONES - 1));
                burst = $urandom_range(1, 6);
                repeat (burst)
                    issue(zhdp_pkg::KIND_MOTION, z, zhdp_pkg::HOUR_W'($urandom),
                          zhdp_pkg::OBS_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    issue(zhdp_pkg::KIND_LEARN, z, rand_hour(), rand_obs());
                issue(zhdp_pkg::KIND_PREDICT, z, rand_hour(), zhdp_pkg::OBS_W'($urandom));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    issue(zhdp_pkg::KIND_MOTION, rand_zone(), zhdp_pkg::HOUR_W'($urandom),
                          zhdp_pkg::OBS_W'($urandom));
                else if (r < 65)
                    issue(zhdp_pkg::KIND_PREDICT, rand_zone(), rand_hour(),
                          zhdp_pkg::OBS_W'($urandom));
                else if (r < 95)
                    issue(zhdp_pkg::KIND_LEARN, rand_zone(), rand_hour(), rand_obs());
                else
                    issue(KIND_RESERVED, rand_zone(), rand_hour(), rand_obs());
            end
        end
        start <= 1'b0;

        // Drain outstanding predictions, then allow the pipeline to settle
        while (sb.demand_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d motion, %0d predict, %0d learn and %0d ignored commands;",
                 sb.n_motion, sb.n_predict, sb.n_learn, sb.n_ignored);
        $display("%0d demand results checked, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.demand_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200000;
        $display("Timed out waiting for the block.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
